// ----- rtl/core/tria_pkg.sv -----
`timescale 1ns / 1ps

package tria_pkg;

  // Sizing of the allocator
  localparam int NUM_KINDS = 5;
  localparam int MAX_SLOTS = 4096;
  localparam int NUM_CFG   = 5;
  localparam int QDEPTH    = 2;

  // Field and register widths
  localparam int SLOT_W    = 12;
  localparam int KIND_W    = 3;
  localparam int CAP_W     = 13;
  localparam int CFG_IDX_W = 3;
  localparam int KCMP_W    = KIND_W + 1;

  // Derived widths
  localparam int PTR_W     = $clog2(MAX_SLOTS);
  localparam int FILL_W    = $clog2(MAX_SLOTS + 1);
  localparam int CMP_W     = (FILL_W > CAP_W) ? FILL_W : CAP_W;
  localparam int KIDX_W    = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;
  localparam int RAM_DEPTH = NUM_KINDS * MAX_SLOTS;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);
  localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  // Capacity register reset values
  localparam logic [CAP_W-1:0] CAP_RESET [NUM_CFG] = '{
    CAP_W'(4096), CAP_W'(4096), CAP_W'(4096), CAP_W'(4096), CAP_W'(1024)
  };

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_FRESH   = 3'd0,
    ST_REUSED  = 3'd1,
    ST_WRAPPED = 3'd2,
    ST_FREED   = 3'd3,
    ST_DROPPED = 3'd4
  } status_e;

  // Work handed from the classifier to the memory side
  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [SLOT_W-1:0] data;
    status_e           status;
  } cmd_t;

  // Advance a ring position, wrapping at the FIFO depth
  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(MAX_SLOTS - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  // Flat free-store address of one kind's ring position
  function automatic logic [ADDR_W-1:0] store_addr(input logic [KIDX_W-1:0] k,
                                                   input logic [PTR_W-1:0]  p);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(k) * ADDR_W'(MAX_SLOTS) + ADDR_W'(p);
    return a;
  endfunction

endpackage

// ----- rtl/core/tria_req_if.sv -----
`timescale 1ns / 1ps

interface tria_req_if;
  import tria_pkg::*;

  logic              valid;
  logic              ready;
  op_e               opcode;
  logic [KIND_W-1:0] res_kind;
  logic [SLOT_W-1:0] freed_slot;

  modport source (output valid, output opcode, output res_kind, output freed_slot,
                  input ready);
  modport sink   (input valid, input opcode, input res_kind, input freed_slot,
                  output ready);
endinterface

// ----- rtl/core/tria_rsp_if.sv -----
`timescale 1ns / 1ps

interface tria_rsp_if;
  import tria_pkg::*;

  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot_out;
  status_e           status;

  modport source (output valid, output slot_out, output status, input ready);
  modport sink   (input valid, input slot_out, input status, output ready);
endinterface

// ----- rtl/core/tria_ram.sv -----
`timescale 1ns / 1ps

module tria_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write or read one entry, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/tria_front.sv -----
`timescale 1ns / 1ps

module tria_front
  import tria_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CAP_W-1:0]     cfg_data_i,
  tria_req_if.sink             req,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output cmd_t                 q_cmd_o
);

  logic [CAP_W-1:0]  cfg_q   [NUM_CFG];
  logic [PTR_W-1:0]  fresh_q [NUM_KINDS];
  logic [PTR_W-1:0]  fresh_d [NUM_KINDS];
  logic [PTR_W-1:0]  head_q  [NUM_KINDS];
  logic [PTR_W-1:0]  head_d  [NUM_KINDS];
  logic [PTR_W-1:0]  tail_q  [NUM_KINDS];
  logic [PTR_W-1:0]  tail_d  [NUM_KINDS];
  logic [FILL_W-1:0] fill_q  [NUM_KINDS];
  logic [FILL_W-1:0] fill_d  [NUM_KINDS];

  logic              accept;
  logic              kind_ok;
  logic              cfg_ok;
  logic [KIDX_W-1:0] kidx;
  logic [CAP_W-1:0]  cap_raw;
  logic [CMP_W-1:0]  cap_eff;
  logic [FILL_W-1:0] fill;
  logic [PTR_W-1:0]  fresh;
  logic [CMP_W-1:0]  fresh_inc;
  logic              reuse;
  logic              wrap;
  logic              free_ok;
  cmd_t              cmd;

  assign req.ready = !q_full_i;
  assign accept    = req.valid && !q_full_i;

  // Classify the request against its kind's counters
  assign kind_ok = (KCMP_W'(req.res_kind) < KCMP_W'(NUM_KINDS));
  assign cfg_ok  = (KCMP_W'(req.res_kind) < KCMP_W'(NUM_CFG));
  assign kidx    = req.res_kind[KIDX_W-1:0];
  assign cap_raw = cfg_ok ? cfg_q[req.res_kind[CFG_IDX_W-1:0]] : CAP_W'(1);

  // Clamp the capacity into 1..MAX_SLOTS
  always_comb begin
    if (cap_raw == '0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(cap_raw) > CMP_W'(MAX_SLOTS)) begin
      cap_eff = CMP_W'(MAX_SLOTS);
    end else begin
      cap_eff = CMP_W'(cap_raw);
    end
  end

  assign fill      = kind_ok ? fill_q[kidx] : '0;
  assign fresh     = kind_ok ? fresh_q[kidx] : '0;
  assign fresh_inc = CMP_W'(fresh) + CMP_W'(1);
  assign reuse     = (fill != '0) && (CMP_W'(fill) >= (cap_eff >> 2));
  assign wrap      = (fresh_inc >= cap_eff);
  assign free_ok   = (fill < FILL_W'(MAX_SLOTS));

  // Build the command and the next counter values
  always_comb begin
    fresh_d    = fresh_q;
    head_d     = head_q;
    tail_d     = tail_q;
    fill_d     = fill_q;
    cmd.rd     = 1'b0;
    cmd.wr     = 1'b0;
    cmd.addr   = '0;
    cmd.data   = '0;
    cmd.status = ST_DROPPED;
    if (kind_ok) begin
      case (req.opcode)
        OP_ALLOC: begin
          if (reuse) begin
            cmd.rd       = 1'b1;
            cmd.addr     = store_addr(kidx, head_q[kidx]);
            cmd.status   = ST_REUSED;
            head_d[kidx] = ptr_next(head_q[kidx]);
            fill_d[kidx] = fill - 1'b1;
          end else begin
            cmd.data = SLOT_W'(fresh);
            if (wrap) begin
              cmd.status    = ST_WRAPPED;
              fresh_d[kidx] = '0;
            end else begin
              cmd.status    = ST_FRESH;
              fresh_d[kidx] = PTR_W'(fresh_inc);
            end
          end
        end
        OP_FREE: begin
          if (free_ok) begin
            cmd.wr       = 1'b1;
            cmd.addr     = store_addr(kidx, tail_q[kidx]);
            cmd.data     = req.freed_slot;
            cmd.status   = ST_FREED;
            tail_d[kidx] = ptr_next(tail_q[kidx]);
            fill_d[kidx] = fill + 1'b1;
          end
        end
        default: begin
          cmd.status = ST_DROPPED;
        end
      endcase
    end
  end

  // Hold counters, advance them on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_KINDS; k++) begin
        fresh_q[k] <= '0;
        head_q[k]  <= '0;
        tail_q[k]  <= '0;
        fill_q[k]  <= '0;
      end
    end else if (accept) begin
      fresh_q <= fresh_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      fill_q  <= fill_d;
    end
  end

  // Capacity registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CAP_RESET;
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_CFG))) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign q_push_o = accept;
  assign q_cmd_o  = cmd;

endmodule

// ----- rtl/core/tria_cmd_q.sv -----
`timescale 1ns / 1ps

module tria_cmd_q
  import tria_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  cmd_t              buf_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q;
  logic [QPTR_W-1:0] rptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = buf_q[rptr_q];

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q] <= cmd_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/tria_back.sv -----
`timescale 1ns / 1ps

module tria_back
  import tria_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_empty_i,
  input  cmd_t     q_cmd_i,
  output logic     q_pop_o,
  tria_rsp_if.source rsp
);

  logic              pop;
  logic              pend_q;
  cmd_t              pend_cmd_q;
  logic [SLOT_W-1:0] rdata;
  logic              out_valid_q;
  logic [SLOT_W-1:0] out_slot_q;
  status_e           out_status_q;

  // Pop when the output register is free by the time the memory answers
  assign pop     = !q_empty_i && !pend_q && (!out_valid_q || rsp.ready);
  assign q_pop_o = pop;

  tria_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (pop && q_cmd_i.wr),
    .re_i    (pop && q_cmd_i.rd),
    .addr_i  (q_cmd_i.addr),
    .wdata_i (q_cmd_i.data),
    .rdata_o (rdata)
  );

  // Hold the command while the memory read is in flight
  always_ff @(posedge clk_i) begin
    if (pop) begin
      pend_cmd_q <= q_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= pop;
    end
  end

  // Load the result, drop it on transfer
  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      out_status_q <= pend_cmd_q.status;
      if (pend_cmd_q.rd) begin
        out_slot_q <= rdata;
      end else if (pend_cmd_q.wr) begin
        out_slot_q <= '0;
      end else begin
        out_slot_q <= pend_cmd_q.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pend_q) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign rsp.valid    = out_valid_q;
  assign rsp.slot_out = out_slot_q;
  assign rsp.status   = out_status_q;

endmodule

// ----- rtl/core/threshold_reuse_index_allocator.sv -----
`timescale 1ns / 1ps

// Slot index allocator for several resource kinds.
// Requests arrive on req (opcode, res_kind, freed_slot) with valid/ready;
// each request gives exactly one result on rsp (slot_out, status), in order.
// An allocate reuses the oldest freed index of its kind once that kind's free
// FIFO holds at least a quarter of the kind's capacity, else it hands out the
// next fresh index. A free queues the index, or reports a drop when full.
// Capacities are written through cfg_we_i / cfg_idx_i / cfg_data_i while idle.
// A result passes through the command queue, the held command register and the
// output register. The back end takes no new command while one is in flight, a
// limit set by the single port of the free-index memory and its registered read.
// The front end classifies and updates the per-kind counters in the cycle of
// the transfer and can take up to two requests ahead of the memory side.
// When rsp is stalled the result is held, the command queue fills, and req
// ready drops once the queue is full.
// Reset clears all counters and FIFO positions and restores the capacities;
// the free-index memory itself is not cleared and needs no clearing pass.

module threshold_reuse_index_allocator
  import tria_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CAP_W-1:0]     cfg_data_i,
  tria_req_if.sink             req,
  tria_rsp_if.source           rsp
);

  logic q_full;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_pop;
  logic q_empty;
  cmd_t q_pop_cmd;

  tria_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_push_cmd)
  );

  tria_cmd_q u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (q_pop_cmd)
  );

  tria_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_cmd_i   (q_pop_cmd),
    .q_pop_o   (q_pop),
    .rsp       (rsp)
  );

endmodule

// ----- test/slot_grant_checker.sv -----
`timescale 1ns / 1ps

// Watches the capacity port and both channels, predicts each slot grant and
// compares it with what the allocator returns.
module slot_grant_checker
  import tria_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CAP_W-1:0]     cfg_data_i,
  tria_req_if                  req,
  tria_rsp_if                  rsp,
  output int                   pending_o,
  output int                   fail_count_o
);

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    status_e           status;
  } grant_t;

  logic [CAP_W-1:0]  cap_q [NUM_CFG];
  logic [SLOT_W-1:0] fresh_ctr [NUM_KINDS];
  logic [SLOT_W-1:0] recycled_q [NUM_KINDS][$];
  grant_t            expected_grants [$];
  int                fail_count = 0;

  // Clamp a capacity register into 1..MAX_SLOTS
  function automatic int unsigned usable_cap(input int kind);
    int unsigned c;
    c = cap_q[kind];
    if (c < 1) c = 1;
    if (c > MAX_SLOTS) c = MAX_SLOTS;
    return c;
  endfunction

  // Work out the grant of one request and advance the per-kind state
  function automatic grant_t predict_grant(input op_e op, input logic [KIND_W-1:0] kind,
                                           input logic [SLOT_W-1:0] slot);
    grant_t      g;
    int unsigned cap;
    int unsigned fill;
    int unsigned nxt;
    g.slot   = '0;
    g.status = ST_DROPPED;
    if (kind < NUM_KINDS) begin
      fill = recycled_q[kind].size();
      if (op == OP_ALLOC) begin
        cap = usable_cap(kind);
        if (fill > 0 && fill >= cap / 4) begin
          g.slot   = recycled_q[kind].pop_front();
          g.status = ST_REUSED;
        end else begin
          // a counter left above a lowered capacity is handed out, then wraps
          g.slot = fresh_ctr[kind];
          nxt    = fresh_ctr[kind] + 1;
          if (nxt >= cap) begin
            fresh_ctr[kind] = '0;
            g.status        = ST_WRAPPED;
          end else begin
            fresh_ctr[kind] = SLOT_W'(nxt);
            g.status        = ST_FRESH;
          end
        end
      end else if (fill < MAX_SLOTS) begin
        recycled_q[kind].push_back(slot);
        g.status = ST_FREED;
      end
    end
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    grant_t want;
    if (!rst_ni) begin
      for (int k = 0; k < NUM_CFG; k++) cap_q[k] = CAP_RESET[k];
      for (int k = 0; k < NUM_KINDS; k++) begin
        fresh_ctr[k] = '0;
        recycled_q[k].delete();
      end
      expected_grants.delete();
    end else begin
      // track capacity writes; out-of-range indexes are ignored
      if (cfg_we_i && cfg_idx_i < NUM_CFG) cap_q[cfg_idx_i] = cfg_data_i;

      // compare a result transfer against the oldest prediction
      if (rsp.valid && rsp.ready) begin
        if (expected_grants.size() == 0) begin
          fail_count++;
          $display("%0t: result slot_out %0d status %0d arrived with none expected",
                   $time, rsp.slot_out, rsp.status);
        end else begin
          want = expected_grants.pop_front();
          if (rsp.slot_out !== want.slot) begin
            fail_count++;
            $display("%0t: slot_out expected %0d got %0d", $time, want.slot, rsp.slot_out);
          end
          if (rsp.status !== want.status) begin
            fail_count++;
            $display("%0t: status expected %0d got %0d", $time, want.status, rsp.status);
          end
        end
      end

      // predict the grant of a request transfer
      if (req.valid && req.ready) begin
        expected_grants.push_back(predict_grant(req.opcode, req.res_kind, req.freed_slot));
      end
    end
    pending_o    = expected_grants.size();
    fail_count_o = fail_count;
  end

endmodule

// ----- test/tb_threshold_reuse_index_allocator.sv -----
`timescale 1ns / 1ps

module tb_threshold_reuse_index_allocator;
  import tria_pkg::*;

  // Capacity register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAP_SBUF    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP_UBUF    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP_SAMPLED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP_STORAGE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP_SAMPLER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED    = 3'd7;

  // Resource kinds
  localparam logic [KIND_W-1:0] KIND_SBUF    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_UBUF    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SAMPLED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_STORAGE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SAMPLER = 3'd4;
  localparam logic [KIND_W-1:0] KIND_BAD_LO  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_BAD_MID = 3'd6;
  localparam logic [KIND_W-1:0] KIND_BAD_HI  = 3'd7;

  localparam int ITEMS_PER_PHASE = 365;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CAP_W-1:0]     cfg_data_i = '0;
  logic                 steady = 1'b0;
  int                   pending;
  int                   fail_count;

  tria_req_if req_bus();
  tria_rsp_if rsp_bus();

  threshold_reuse_index_allocator uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req       (req_bus),
    .rsp       (rsp_bus)
  );

  slot_grant_checker u_grant_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .req         (req_bus),
    .rsp         (rsp_bus),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  always #1 clk_i = ~clk_i;

  // Stall the result side at random unless in a steady stretch
  always @(negedge clk_i) begin
    rsp_bus.ready <= steady || ($urandom_range(99, 0) >= 16);
  end

  // Bound the run
  initial begin
    #2000000;
    $display("threshold_reuse_index_allocator: mismatch");
    $finish;
  end

  // Write one capacity register while the allocator is idle
  task automatic write_cap(input logic [CFG_IDX_W-1:0] idx, input logic [CAP_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic set_caps(input int c0, input int c1, input int c2, input int c3,
                          input int c4);
    write_cap(CFG_CAP_SBUF, CAP_W'(c0));
    write_cap(CFG_CAP_UBUF, CAP_W'(c1));
    write_cap(CFG_CAP_SAMPLED, CAP_W'(c2));
    write_cap(CFG_CAP_STORAGE, CAP_W'(c3));
    write_cap(CFG_CAP_SAMPLER, CAP_W'(c4));
  endtask

  // Present one request, with an occasional gap, and hold it until transfer
  task automatic send_item(input op_e op, input logic [KIND_W-1:0] kind,
                           input logic [SLOT_W-1:0] slot);
    @(negedge clk_i);
    if (!steady && $urandom_range(99, 0) < 16) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    req_bus.valid      <= 1'b1;
    req_bus.opcode     <= op;
    req_bus.res_kind   <= kind;
    req_bus.freed_slot <= slot;
    do @(posedge clk_i); while (!req_bus.ready);
  endtask

  // Drop valid and hold until every grant is back and the pipe is empty
  task automatic drain();
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Mostly legal kinds, some out of range; slots full range or near zero
  task automatic send_random();
    op_e               op;
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    op   = op_e'($urandom_range(1, 0));
    kind = ($urandom_range(9, 0) == 0) ? KIND_W'($urandom_range(7, 5))
                                       : KIND_W'($urandom_range(4, 0));
    slot = $urandom_range(1, 0) ? SLOT_W'($urandom_range(4095, 0))
                                : SLOT_W'($urandom_range(15, 0));
    send_item(op, kind, slot);
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) send_random();
    drain();
  endtask

  initial begin
    req_bus.valid      = 1'b0;
    req_bus.opcode     = OP_ALLOC;
    req_bus.res_kind   = '0;
    req_bus.freed_slot = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: fresh grants, frees at the slot extremes, bad kinds
    send_item(OP_ALLOC, KIND_SBUF, 12'h000);
    send_item(OP_ALLOC, KIND_SBUF, 12'hFFF);
    send_item(OP_FREE, KIND_SBUF, 12'hFFF);
    send_item(OP_FREE, KIND_SBUF, 12'h000);
    send_item(OP_ALLOC, KIND_SBUF, 12'h000);
    for (int i = 0; i < 5; i++) send_item(OP_ALLOC, KIND_UBUF, 12'h000);
    send_item(OP_FREE, KIND_SAMPLED, 12'hAAA);
    send_item(OP_FREE, KIND_SAMPLED, 12'h555);
    send_item(OP_ALLOC, KIND_SAMPLER, 12'h000);
    send_item(OP_ALLOC, KIND_BAD_LO, 12'h000);
    send_item(OP_FREE, KIND_BAD_MID, 12'h123);
    send_item(OP_ALLOC, KIND_BAD_HI, 12'hFFF);
    send_item(OP_FREE, KIND_BAD_HI, 12'hFFF);
    drain();

    // directed: zero and oversized capacity, counter above capacity,
    // reuse at a zero threshold, write to an unmapped index
    write_cap(CFG_CAP_SBUF, 13'd0);
    write_cap(CFG_CAP_UBUF, 13'd3);
    write_cap(CFG_CAP_SAMPLED, 13'h1FFF);
    write_cap(CFG_CAP_SAMPLER, 13'd4);
    write_cap(CFG_UNMAPPED, 13'd5);
    for (int i = 0; i < 4; i++) send_item(OP_ALLOC, KIND_UBUF, 12'h000);
    send_item(OP_ALLOC, KIND_SBUF, 12'h000);
    send_item(OP_ALLOC, KIND_SBUF, 12'h000);
    send_item(OP_ALLOC, KIND_SBUF, 12'h000);
    send_item(OP_ALLOC, KIND_SAMPLER, 12'h000);
    send_item(OP_FREE, KIND_SAMPLER, 12'h007);
    send_item(OP_ALLOC, KIND_SAMPLER, 12'h000);
    send_item(OP_ALLOC, KIND_SAMPLED, 12'h000);
    drain();

    // queue a long run of frees on one kind, reuse down past the threshold
    write_cap(CFG_CAP_STORAGE, 13'd256);
    for (int i = 0; i < 128; i++) send_item(OP_FREE, KIND_STORAGE, SLOT_W'(i));
    for (int i = 0; i < 80; i++) send_item(OP_ALLOC, KIND_STORAGE, 12'h000);
    send_item(OP_FREE, KIND_STORAGE, 12'hABC);
    drain();

    // random: tiny capacities, frequent wraps and reuse
    set_caps(1, 2, 3, 4, 5);
    run_random(ITEMS_PER_PHASE);

    // random: long stretch with no idling on either side
    steady <= 1'b1;
    set_caps(8, 16, 0, 7, 12);
    run_random(ITEMS_PER_PHASE);
    steady <= 1'b0;

    // random: assorted small capacities, one above the slot range
    set_caps($urandom_range(64, 1), $urandom_range(64, 1), $urandom_range(64, 1),
             $urandom_range(64, 1), 8191);
    run_random(ITEMS_PER_PHASE);

    // random: full-size and oversized capacities, one of them only 2
    set_caps(4096, 4097, 2, 4096, 1024);
    run_random(ITEMS_PER_PHASE);

    if (fail_count == 0) begin
      $display("threshold_reuse_index_allocator: match");
    end else begin
      $display("threshold_reuse_index_allocator: mismatch");
    end
    $finish;
  end

endmodule
